// ----- hw/rtl/skf_pkg.sv -----
package skf_pkg;

    localparam int DATA_W   = 32;
    localparam int GAIN_W   = 17;
    localparam int FRAC_W   = 16;
    localparam int STEP_W   = 3;
    localparam int UC_DEPTH = 8;
    localparam int CNT_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(1) << FRAC_W;

    typedef logic [STEP_W-1:0] step_t;

    // datapath operations
    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_LOAD = 3'd1;  // take a word, form P+R and innovation
    localparam logic [2:0] OP_DIV0 = 3'd2;  // first quotient bit, no shift
    localparam logic [2:0] OP_DIVS = 3'd3;  // shift, compare, subtract
    localparam logic [2:0] OP_FIX  = 3'd4;  // zero the gain on a zero denominator
    localparam logic [2:0] OP_MULP = 3'd5;  // (1 - K) * P
    localparam logic [2:0] OP_MULI = 3'd6;  // write P, K * innovation
    localparam logic [2:0] OP_EST  = 3'd7;  // new estimate into the output register

    // jump conditions: jump to target when true, else advance
    localparam logic [2:0] JC_NEXT     = 3'd0;
    localparam logic [2:0] JC_IN_WAIT  = 3'd1;
    localparam logic [2:0] JC_LOOP     = 3'd2;
    localparam logic [2:0] JC_OUT_WAIT = 3'd3;
    localparam logic [2:0] JC_ALWAYS   = 3'd4;

    localparam step_t STEP_IDLE = 3'd0;
    localparam step_t STEP_DIV0 = 3'd1;
    localparam step_t STEP_DIVS = 3'd2;
    localparam step_t STEP_FIX  = 3'd3;
    localparam step_t STEP_MULP = 3'd4;
    localparam step_t STEP_MULI = 3'd5;
    localparam step_t STEP_EST  = 3'd6;
    localparam step_t STEP_RET  = 3'd7;

    localparam int CFG_START_ESTIMATE = 0;
    localparam int CFG_NOISE_VARIANCE = 1;
    localparam int CFG_START_ERROR    = 2;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] jc;
        step_t      target;
    } ucode_word_t;

    localparam ucode_word_t UCODE_ROM [UC_DEPTH] = '{
        '{OP_LOAD, JC_IN_WAIT,  STEP_IDLE},
        '{OP_DIV0, JC_NEXT,     STEP_IDLE},
        '{OP_DIVS, JC_LOOP,     STEP_DIVS},
        '{OP_FIX,  JC_NEXT,     STEP_IDLE},
        '{OP_MULP, JC_NEXT,     STEP_IDLE},
        '{OP_MULI, JC_NEXT,     STEP_IDLE},
        '{OP_EST,  JC_OUT_WAIT, STEP_EST},
        '{OP_NOP,  JC_ALWAYS,   STEP_IDLE}
    };

endpackage

// ----- hw/rtl/scalar_kalman_filter_core.sv -----
// Scalar Kalman filter in Q16.16 fixed point. Each input word carries one
// signed measurement z; the core keeps an estimate x and an error variance P
// and per word computes K = P/(P+R) in Q1.16 (0 when P+R is zero), then
// P = (1-K)*P and x = x + K*(z-x), all scalings by 1/65536 rounding toward
// minus infinity, and returns the new x (saturated) with the gain K. A short
// microprogram of eight control words sequences a restoring divider and one
// shared 18x34 multiplier. Each word passes an accept step, 17 divider
// steps, the gain fix, two multiplies, the estimate update and a return
// step before the next word can be accepted. A finished result
// sits in an output register, so the next word is taken while it waits;
// the core holds in its last update step only if the previous result is
// still not taken. Writing start_estimate loads x, writing start_error loads
// P, noise_variance sets R; write the configuration only while idle.
module scalar_kalman_filter_core
    import skf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] measurement
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [55:0]           m_tdata    // [31:0] filtered, [48:32] gain_used
);

    localparam int SUM_W  = DATA_W + 1;        // P + R
    localparam int REM_W  = DATA_W + 2;        // shifted partial remainder
    localparam int MULB_W = DATA_W + 2;
    localparam int PROD_W = GAIN_W + MULB_W;   // signed product of 18 x 34
    localparam int EST_W  = DATA_W + 4;

    // sequencer
    step_t             step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    ucode_word_t       uc;
    logic              jump;

    // filter state and datapath
    logic signed [DATA_W-1:0] est_reg, est_next;
    logic [DATA_W-1:0]        perr_reg, perr_next;
    logic [DATA_W-1:0]        noise_reg, noise_next;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [GAIN_W-1:0]        gain_reg, gain_next;
    logic signed [SUM_W-1:0]  innov_reg, innov_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // output register
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] filt_reg, filt_next;
    logic [GAIN_W-1:0]        gout_reg, gout_next;

    logic in_accept, out_free;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic [GAIN_W-1:0]        mul_a;
    logic signed [MULB_W-1:0] mul_b;
    logic signed [EST_W-1:0]  est_wide;

    assign uc        = UCODE_ROM[step_reg];
    assign s_tready  = (uc.op == OP_LOAD);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, gout_reg, filt_reg};

    // divider: one quotient bit per step
    assign trial = (uc.op == OP_DIVS) ? {rem_reg[REM_W-2:0], 1'b0} : rem_reg;
    assign ge    = (trial >= {1'b0, sum_reg});

    // shared multiplier operands
    always_comb begin
        if (uc.op == OP_MULP) begin
            mul_a = ONE_Q16 - gain_reg;
            mul_b = $signed({2'b00, perr_reg});
        end else begin
            mul_a = gain_reg;
            mul_b = MULB_W'(innov_reg);
        end
    end

    // x + floor(K * innov / 65536)
    assign est_wide = EST_W'(est_reg) + EST_W'(prod_reg >>> FRAC_W);

    // step sequencing
    always_comb begin
        case (uc.jc)
            JC_NEXT:     jump = 1'b0;
            JC_IN_WAIT:  jump = !in_accept;
            JC_LOOP:     jump = (cnt_reg != '0);
            JC_OUT_WAIT: jump = !out_free;
            JC_ALWAYS:   jump = 1'b1;
            default:     jump = 1'b0;
        endcase
        step_next = jump ? uc.target : step_reg + step_t'(1);
    end

    // datapath
    always_comb begin
        cnt_next     = cnt_reg;
        est_next     = est_reg;
        perr_next    = perr_reg;
        noise_next   = noise_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        gain_next    = gain_reg;
        innov_next   = innov_reg;
        prod_next    = $signed({1'b0, mul_a}) * mul_b;
        m_valid_next = m_valid_reg;
        filt_next    = filt_reg;
        gout_next    = gout_reg;

        // retire a taken result
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (uc.op)
            OP_LOAD: begin
                if (in_accept) begin
                    sum_next   = {1'b0, perr_reg} + {1'b0, noise_reg};
                    rem_next   = REM_W'(perr_reg);
                    innov_next = SUM_W'($signed(s_tdata)) - SUM_W'(est_reg);
                    cnt_next   = '1;
                end
            end
            OP_DIV0, OP_DIVS: begin
                rem_next  = ge ? trial - REM_W'(sum_reg) : trial;
                gain_next = {gain_reg[GAIN_W-2:0], ge};
                if (uc.op == OP_DIVS) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            OP_FIX: begin
                // zero denominator: gain of zero, P and x stay
                if (sum_reg == '0) begin
                    gain_next = '0;
                end
            end
            OP_MULI: begin
                perr_next = prod_reg[FRAC_W +: DATA_W];
            end
            OP_EST: begin
                if (out_free) begin
                    if (est_wide > EST_W'(32'sh7FFF_FFFF)) begin
                        est_next = 32'sh7FFF_FFFF;
                    end else if (est_wide < -EST_W'(32'sh7FFF_FFFF) - EST_W'(1)) begin
                        est_next = 32'sh8000_0000;
                    end else begin
                        est_next = est_wide[DATA_W-1:0];
                    end
                    filt_next    = est_next;
                    gout_next    = gain_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // configuration; the user writes it only while idle, the core does not enforce this
        if (cfg_we) begin
            case (int'(cfg_index))
                CFG_START_ESTIMATE: est_next   = $signed(cfg_wdata);
                CFG_NOISE_VARIANCE: noise_next = cfg_wdata;
                CFG_START_ERROR:    perr_next  = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            est_reg     <= '0;
            noise_reg   <= DATA_W'(6554);
            perr_reg    <= DATA_W'(65536);
        end else begin
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            est_reg     <= est_next;
            noise_reg   <= noise_next;
            perr_reg    <= perr_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        sum_reg   <= sum_next;
        rem_reg   <= rem_next;
        gain_reg  <= gain_next;
        innov_reg <= innov_next;
        prod_reg  <= prod_next;
        filt_reg  <= filt_next;
        gout_reg  <= gout_next;
    end

    // an accepted word starts the divider next cycle
    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (step_reg == STEP_DIV0))
        else $error("accepted word did not start the divider");

    // a zero denominator always yields a zero gain
    a_zero_sum_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == STEP_FIX && sum_reg == '0) |=> (gain_reg == '0))
        else $error("zero denominator gave a nonzero gain");

    // the reported gain never exceeds one
    a_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48:32] <= ONE_Q16))
        else $error("gain above 1.0 on output");

    // the output register is never overwritten while a result waits
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && step_reg == STEP_EST) |=> (step_reg == STEP_EST))
        else $error("estimate update left while output blocked");

endmodule

// ----- sim/testbench.sv -----
module testbench
    import skf_pkg::*;
();

    // register indexes as the write port sees them; index 3 maps to nothing
    localparam logic [CFG_IDX_W-1:0] REG_START_EST = CFG_IDX_W'(CFG_START_ESTIMATE);
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_VAR = CFG_IDX_W'(CFG_NOISE_VARIANCE);
    localparam logic [CFG_IDX_W-1:0] REG_START_ERR = CFG_IDX_W'(CFG_START_ERROR);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED  = CFG_IDX_W'(3);

    localparam logic [DATA_W-1:0] RESET_NOISE_VAR = 32'd6554;
    localparam logic [DATA_W-1:0] RESET_START_ERR = 32'd65536;

    localparam logic [DATA_W-1:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] U_MAX = 32'hFFFF_FFFF;

    localparam int RANDOM_WORDS   = 1750;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic [DATA_W-1:0] filtered;
        logic [GAIN_W-1:0] gain;
    } kalman_result_t;

    // Filter state mirror plus the queue of results still owed by the core.
    class kalman_scoreboard;
        logic [DATA_W-1:0] estimate;
        logic [DATA_W-1:0] noise_var;
        logic [DATA_W-1:0] err_var;
        kalman_result_t    owed_results[$];
        int                mismatches;

        function new();
            estimate   = '0;
            noise_var  = RESET_NOISE_VAR;
            err_var    = RESET_START_ERR;
            mismatches = 0;
        endfunction

        function void load_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_START_EST: estimate = value;
                REG_NOISE_VAR: noise_var = value;
                REG_START_ERR: err_var = value;
                default: ;
            endcase
        endfunction

        // One filter update: gain, new variance, new saturated estimate.
        function void note_measurement(logic [DATA_W-1:0] z_bits);
            longint p, sum, k, z, x, innov, x_new;
            kalman_result_t res;
            p   = longint'(err_var);
            sum = p + longint'(noise_var);
            k   = (sum != 0) ? ((p <<< FRAC_W) / sum) : 0;
            if (k > longint'(ONE_Q16))
                k = longint'(ONE_Q16);
            err_var = DATA_W'(((longint'(ONE_Q16) - k) * p) >>> FRAC_W);
            z     = longint'(signed'(z_bits));
            x     = longint'(signed'(estimate));
            innov = z - x;
            x_new = x + ((k * innov) >>> FRAC_W);
            if (x_new > longint'(signed'(S_MAX)))
                x_new = longint'(signed'(S_MAX));
            if (x_new < longint'(signed'(S_MIN)))
                x_new = longint'(signed'(S_MIN));
            estimate     = DATA_W'(x_new);
            res.filtered = estimate;
            res.gain     = GAIN_W'(k);
            owed_results.push_back(res);
        endfunction

        task flag_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [55:0] word);
            kalman_result_t want;
            logic [DATA_W-1:0] got_filtered;
            logic [GAIN_W-1:0] got_gain;
            got_filtered = word[DATA_W-1:0];
            got_gain     = word[DATA_W+GAIN_W-1:DATA_W];
            if (owed_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result word %h", word));
            end else begin
                want = owed_results.pop_front();
                if (got_filtered !== want.filtered)
                    flag_mismatch($sformatf("filtered got %h want %h",
                                            got_filtered, want.filtered));
                if (got_gain !== want.gain)
                    flag_mismatch($sformatf("gain_used got %h want %h",
                                            got_gain, want.gain));
            end
        endtask

        function int owed();
            return owed_results.size();
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [55:0]          m_tdata;

    kalman_scoreboard sb = new();

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int rx_hold = 0;
    int idle_cycles = 0;

    scalar_kalman_filter_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 4-unit clock period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_variance();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return U_MAX;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_estimate();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Sensor-like samples: noise around a center most of the time, plus
    // arbitrary words and the field extremes.
    function automatic logic [DATA_W-1:0] next_measurement(logic [DATA_W-1:0] center);
        longint v;
        int     k;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            k = $urandom_range(0, 20);
            v = longint'(signed'(center)) + longint'($urandom_range(0, 2 << k))
                - (longint'(1) <<< k);
            if (v > longint'(signed'(S_MAX)))
                v = longint'(signed'(S_MAX));
            if (v < longint'(signed'(S_MIN)))
                v = longint'(signed'(S_MIN));
            return DATA_W'(v);
        end
        if (r < 85)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            default: return U_MAX;
        endcase
    endfunction

    // Present one word at the falling edge, hold until the core takes it,
    // then drop valid for the requested gap. With no gap valid stays high.
    task automatic send_measurement(input logic [DATA_W-1:0] z, input int gap);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = z;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // One register write, enable high for exactly one rising edge.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(posedge aclk);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Stop sending and hold until every owed result has come back.
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.owed() != 0)
            @(posedge aclk);
    endtask

    // Result side: stall at random, except in burst phases.
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready = 1'b0;
            rx_hold--;
        end else begin
            m_tready = 1'b1;
            if (!rx_burst && $urandom_range(0, 3) == 0)
                rx_hold = pick_gap();
        end
    end

    // Sample every handshake at the rising edge; check results before
    // recording new inputs so the queue order holds.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (s_tvalid && s_tready)
                sb.note_measurement(s_tdata);
            if (cfg_we)
                sb.load_register(cfg_index, cfg_wdata);
        end
    end

    // Abort when nothing moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        int phase_len;
        logic [DATA_W-1:0] center;

        // hold reset, then release it at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset configuration: field extremes and rounding of small negatives
        send_measurement('0, 0);
        send_measurement(S_MAX, 0);
        send_measurement(S_MIN, 0);
        send_measurement(U_MAX, 1);
        send_measurement(32'd1, 0);
        send_measurement(32'h0001_0000, 0);
        wait_for_results();

        // zero denominator: P and R both zero, gain must be zero
        write_cfg(REG_NOISE_VAR, '0);
        write_cfg(REG_START_ERR, '0);
        send_measurement(32'h1234_5678, 0);
        send_measurement(S_MIN, 0);
        wait_for_results();

        // full gain: R zero, P huge, estimate at the bottom, sample at the top
        write_cfg(REG_START_EST, S_MIN);
        write_cfg(REG_START_ERR, U_MAX);
        send_measurement(S_MAX, 0);
        send_measurement(S_MIN, 0);
        wait_for_results();

        // both variances at maximum, estimate at the top
        write_cfg(REG_START_EST, S_MAX);
        write_cfg(REG_NOISE_VAR, U_MAX);
        write_cfg(REG_START_ERR, U_MAX);
        send_measurement(S_MIN, 0);
        send_measurement(S_MAX, 0);
        wait_for_results();

        // zero P with nonzero R, then a write to an unmapped index
        write_cfg(REG_START_ERR, '0);
        write_cfg(REG_UNMAPPED, U_MAX);
        send_measurement(32'h5555_5555, 0);
        send_measurement(32'hAAAA_AAAA, 0);
        wait_for_results();

        // back to the reset-like setup with a negative estimate
        write_cfg(REG_START_EST, 32'hFFFF_8000);
        write_cfg(REG_NOISE_VAR, RESET_NOISE_VAR);
        write_cfg(REG_START_ERR, RESET_START_ERR);
        send_measurement(32'hFFFF_FFFF, 0);
        send_measurement(32'hFFFE_0001, 0);
        send_measurement(32'h0000_7FFF, 0);

        // random phases: drain, reconfigure, then a run of samples
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            wait_for_results();
            if ($urandom_range(0, 1) == 0)
                write_cfg(REG_START_EST, pick_estimate());
            if ($urandom_range(0, 3) != 0)
                write_cfg(REG_START_ERR, pick_variance());
            if ($urandom_range(0, 2) == 0)
                write_cfg(REG_NOISE_VAR, pick_variance());
            if ($urandom_range(0, 19) == 0)
                write_cfg(REG_UNMAPPED, $urandom);
            tx_burst  = ($urandom_range(0, 3) == 0);
            rx_burst  = ($urandom_range(0, 3) == 0);
            center    = pick_estimate();
            phase_len = $urandom_range(4, 60);
            repeat (phase_len) begin
                send_measurement(next_measurement(center), tx_burst ? 0 : pick_gap());
                sent++;
            end
        end

        // drain and let the core settle before judging
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.owed() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
